### sv/bpp_pkg.sv
// Package for the prism projector and face culler.
// Holds field widths, face and register codes, stage payload types and the vertex table.
// Depends on nothing.
`default_nettype none
package bpp_pkg;
    localparam int PRISM_WIDTH_DEF = 16;
    localparam int DH_RESET = 480;
    localparam int VD_RESET = 400;

    localparam int CORD_W = 17;
    localparam int NUM_W = 27;
    localparam int DEN_W = 14;
    localparam int Q_W = 15;
    localparam int QZ_W = 11;
    localparam int LANES = 8;

    localparam logic REG_DISPLAY_HEIGHT = 1'b0;
    localparam logic REG_VIEW_DISTANCE = 1'b1;

    localparam logic [1:0] FACE_FRONT = 2'd0;
    localparam logic [1:0] FACE_TOP = 2'd1;
    localparam logic [1:0] FACE_RIGHT = 2'd2;
    localparam logic [1:0] FACE_LEFT = 2'd3;

    typedef struct packed {
        logic [3:0][CORD_W-1:0] raw;
        logic [3:0] neg;
        logic [1:0][DEN_W-1:0] den;
        logic [1:0] zpos;
        logic [QZ_W-1:0] qz;
        logic zneg;
    } side_t;

    typedef logic [3:0][NUM_W-1:0] num_t;
    typedef logic [LANES-1:0][Q_W-1:0] quot_t;

    function automatic logic [2:0] corner_of(input logic [1:0] face, input logic [2:0] vtx);
        logic [2:0] c;
        c = 3'd0;
        unique case (face)
            FACE_FRONT: begin
                case (vtx)
                    3'd1: c = 3'd1;
                    3'd2: c = 3'd5;
                    3'd3: c = 3'd4;
                    default: c = 3'd0;
                endcase
            end
            FACE_TOP: begin
                case (vtx)
                    3'd1: c = 3'd5;
                    3'd2: c = 3'd6;
                    3'd3: c = 3'd7;
                    default: c = 3'd4;
                endcase
            end
            FACE_RIGHT: begin
                case (vtx)
                    3'd1: c = 3'd2;
                    3'd2: c = 3'd6;
                    3'd3: c = 3'd5;
                    default: c = 3'd1;
                endcase
            end
            default: begin
                case (vtx)
                    3'd1: c = 3'd3;
                    3'd2: c = 3'd7;
                    3'd3: c = 3'd4;
                    default: c = 3'd0;
                endcase
            end
        endcase
        return c;
    endfunction
endpackage
`default_nettype wire

### sv/bpp_front.sv
// Front stages: corner coordinates at accept, then products, divisors and depth quotient.
// Depends on bpp_pkg.
`default_nettype none
module bpp_front #(
    parameter int PRISM_WIDTH = bpp_pkg::PRISM_WIDTH_DEF
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     en,
    input  wire                     in_valid,
    input  wire signed [11:0]       pos_x,
    input  wire signed [11:0]       pos_depth,
    input  wire signed [11:0]       base_y,
    input  wire [9:0]               prism_height,
    input  wire [12:0]              display_height,
    input  wire [11:0]              view_distance,
    output logic                    out_valid,
    output bpp_pkg::num_t           out_num,
    output bpp_pkg::side_t          out_side
);
    import bpp_pkg::*;

    localparam logic signed [CORD_W-1:0] XR_OFS = CORD_W'(5 * PRISM_WIDTH);
    localparam logic signed [14:0] ZB_OFS = 15'(3 * PRISM_WIDTH);
    localparam logic [31:0] RECIP_W = 32'((1 << 20) / PRISM_WIDTH + 1);

    logic a_valid_reg;
    logic [3:0][CORD_W-1:0] a_n_reg;
    logic [1:0][14:0] a_z_reg;
    logic [11:0] a_zabs_reg;
    logic a_zneg_reg;

    logic signed [CORD_W-1:0] xl, xr, yb, yt, ye, hgt_e, dh_e;
    logic signed [14:0] zf;

    always_comb begin
        xl = CORD_W'(pos_x) * CORD_W'(10);
        xr = xl + XR_OFS;
        ye = CORD_W'(base_y);
        hgt_e = CORD_W'(prism_height);
        yb = ye * CORD_W'(10);
        yt = (ye + hgt_e) * CORD_W'(10);
        dh_e = CORD_W'(display_height);
        zf = 15'(pos_depth) * 15'(3);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
        if (en) begin
            a_n_reg[0] <= xl;
            a_n_reg[1] <= xr;
            a_n_reg[2] <= dh_e - yb;
            a_n_reg[3] <= dh_e - yt;
            a_z_reg[0] <= zf;
            a_z_reg[1] <= zf + ZB_OFS;
            a_zneg_reg <= pos_depth[11];
            a_zabs_reg <= pos_depth[11] ? 12'(-pos_depth) : 12'(pos_depth);
        end
    end

    logic [3:0][29:0] prod;
    logic [31:0] qz_prod;
    logic [1:0][14:0] den_sum;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            prod[i] = 30'($signed(a_n_reg[i])) * 30'($signed({1'b0, view_distance}));
        end
        for (int j = 0; j < 2; j++) begin
            den_sum[j] = {3'b000, view_distance} + a_z_reg[j];
        end
        qz_prod = 32'(a_zabs_reg) * RECIP_W;
    end

    logic b_valid_reg;
    num_t b_num_reg;
    side_t b_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                b_num_reg[i] <= prod[i][29] ? NUM_W'(-prod[i]) : NUM_W'(prod[i]);
                b_side_reg.neg[i] <= prod[i][29];
                b_side_reg.raw[i] <= a_n_reg[i];
            end
            for (int j = 0; j < 2; j++) begin
                b_side_reg.den[j] <= den_sum[j][DEN_W-1:0];
                b_side_reg.zpos[j] <= !a_z_reg[j][14] && (a_z_reg[j] != 15'd0);
            end
            b_side_reg.qz <= qz_prod[20 +: QZ_W];
            b_side_reg.zneg <= a_zneg_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_num = b_num_reg;
    assign out_side = b_side_reg;
endmodule
`default_nettype wire

### sv/bpp_div.sv
// Pipelined restoring divider, eight lanes, one quotient bit per stage.
// Depends on bpp_pkg.
`default_nettype none
module bpp_div (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     en,
    input  wire                     in_valid,
    input  bpp_pkg::num_t           in_num,
    input  bpp_pkg::side_t          in_side,
    output logic                    out_valid,
    output bpp_pkg::quot_t          out_quot,
    output bpp_pkg::side_t          out_side
);
    import bpp_pkg::*;

    localparam int CMP_W = NUM_W + 2;

    logic valid_reg [Q_W];
    side_t side_reg [Q_W];
    logic [NUM_W-1:0] rem_reg [Q_W][LANES];
    logic [Q_W-1:0] q_reg [Q_W][LANES];

    logic v_in [Q_W];
    side_t s_in [Q_W];
    logic [NUM_W-1:0] r_in [Q_W][LANES];
    logic [Q_W-1:0] q_in [Q_W][LANES];
    logic [NUM_W-1:0] rem_next [Q_W][LANES];
    logic [Q_W-1:0] q_next [Q_W][LANES];
    logic [CMP_W-1:0] dsh [Q_W][LANES];

    always_comb begin
        v_in[0] = in_valid;
        s_in[0] = in_side;
        for (int l = 0; l < LANES; l++) begin
            r_in[0][l] = in_num[{l[2], l[0]}];
            q_in[0][l] = '0;
        end
        for (int k = 1; k < Q_W; k++) begin
            v_in[k] = valid_reg[k-1];
            s_in[k] = side_reg[k-1];
            for (int l = 0; l < LANES; l++) begin
                r_in[k][l] = rem_reg[k-1][l];
                q_in[k][l] = q_reg[k-1][l];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < Q_W; k++) begin
            for (int l = 0; l < LANES; l++) begin
                dsh[k][l] = CMP_W'(s_in[k].den[l[1]]) << (Q_W - 1 - k);
                if (CMP_W'(r_in[k][l]) >= dsh[k][l]) begin
                    rem_next[k][l] = NUM_W'(CMP_W'(r_in[k][l]) - dsh[k][l]);
                    q_next[k][l] = q_in[k][l] | (Q_W'(1) << (Q_W - 1 - k));
                end else begin
                    rem_next[k][l] = r_in[k][l];
                    q_next[k][l] = q_in[k][l];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < Q_W; k++) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in[k];
            end
        end
        if (en) begin
            for (int k = 0; k < Q_W; k++) begin
                side_reg[k] <= s_in[k];
                for (int l = 0; l < LANES; l++) begin
                    rem_reg[k][l] <= rem_next[k][l];
                    q_reg[k][l] <= q_next[k][l];
                end
            end
        end
    end

    always_comb begin
        out_valid = valid_reg[Q_W-1];
        out_side = side_reg[Q_W-1];
        for (int l = 0; l < LANES; l++) begin
            out_quot[l] = q_reg[Q_W-1][l];
        end
    end
endmodule
`default_nettype wire

### sv/bpp_emit.sv
// Result buffer and face sequencer: signs the quotients, culls faces, emits vertex words.
// Depends on bpp_pkg.
`default_nettype none
module bpp_emit (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     in_valid,
    input  bpp_pkg::quot_t          in_quot,
    input  bpp_pkg::side_t          in_side,
    output logic                    ld_ready,
    output logic                    m_valid,
    input  wire                     m_ready,
    output logic [1:0]              m_face_kind,
    output logic signed [5:0]       m_draw_layer,
    output logic signed [15:0]      m_point_x,
    output logic signed [16:0]      m_point_y,
    output logic                    m_face_start,
    output logic                    m_last
);
    import bpp_pkg::*;

    localparam logic [31:0] RECIP_31 = 32'((1 << 20) / 31 + 1);

    logic buf_valid_reg;
    logic [1:0] face_reg;
    logic [2:0] vtx_reg;
    logic signed [15:0] sx_reg [4];
    logic signed [16:0] sy_reg [4];
    logic signed [5:0] layer_reg;
    logic [3:1] vis_reg;

    logic signed [CORD_W-1:0] val [LANES];
    logic [31:0] lq_prod;
    logic [5:0] lq;
    logic [4:0] lrem;
    logic signed [5:0] layer_next;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (in_side.zpos[l[1]]) begin
                val[l] = in_side.neg[{l[2], l[0]}] ? -$signed(CORD_W'(in_quot[l]))
                                                   : $signed(CORD_W'(in_quot[l]));
            end else begin
                val[l] = $signed(in_side.raw[{l[2], l[0]}]);
            end
        end
        lq_prod = 32'(in_side.qz) * RECIP_31;
        lq = lq_prod[25:20];
        lrem = 5'(in_side.qz - QZ_W'(lq) * QZ_W'(31));
        layer_next = in_side.zneg ? -$signed(6'(lrem)) : $signed(6'(lrem));
    end

    logic [1:0] nf;
    logic more;
    logic [3:0] vis;
    logic take;
    logic load;

    always_comb begin
        vis = {vis_reg, 1'b1};
        nf = face_reg;
        more = 1'b0;
        for (int f = 3; f >= 1; f--) begin
            if (f > int'(face_reg) && vis[f]) begin
                nf = 2'(f);
                more = 1'b1;
            end
        end
        take = buf_valid_reg && m_ready;
        m_last = (vtx_reg == 3'd4) && !more;
        ld_ready = !buf_valid_reg || (take && m_last);
        load = in_valid && ld_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_valid_reg <= 1'b0;
            face_reg <= FACE_FRONT;
            vtx_reg <= 3'd0;
        end else if (load) begin
            buf_valid_reg <= 1'b1;
            face_reg <= FACE_FRONT;
            vtx_reg <= 3'd0;
        end else if (take) begin
            if (m_last) begin
                buf_valid_reg <= 1'b0;
                face_reg <= FACE_FRONT;
                vtx_reg <= 3'd0;
            end else if (vtx_reg == 3'd4) begin
                face_reg <= nf;
                vtx_reg <= 3'd0;
            end else begin
                vtx_reg <= vtx_reg + 3'd1;
            end
        end
        if (load) begin
            for (int j = 0; j < 4; j++) begin
                sx_reg[j] <= val[j][15:0];
                sy_reg[j] <= val[4 + j];
            end
            layer_reg <= layer_next;
            vis_reg[1] <= val[5] > val[7];
            vis_reg[2] <= val[1] < val[3];
            vis_reg[3] <= val[0] > val[2];
        end
    end

    logic [2:0] corner;
    logic [1:0] sx_sel, sy_sel;

    always_comb begin
        corner = corner_of(face_reg, vtx_reg);
        sx_sel = {corner[1], corner[1] ^ corner[0]};
        sy_sel = {corner[1], corner[2]};
        m_valid = buf_valid_reg;
        m_face_kind = face_reg;
        m_face_start = (vtx_reg == 3'd0);
        m_point_y = sy_reg[sy_sel];
        m_point_x = sx_reg[sx_sel] + ((face_reg == FACE_RIGHT) ? 16'sd1 : 16'sd0);
        case (face_reg)
            FACE_FRONT: m_draw_layer = (layer_reg < 6'sd30) ? layer_reg + 6'sd2 : 6'sd31;
            FACE_TOP: m_draw_layer = (layer_reg < 6'sd31) ? layer_reg + 6'sd1 : 6'sd31;
            default: m_draw_layer = layer_reg;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_vtx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vtx_reg <= 3'd4) else $error("vertex counter out of range");
    a_face_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_valid_reg && (face_reg != FACE_FRONT) |-> vis[face_reg])
        else $error("culled face is being emitted");
    a_load_front: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (face_reg == FACE_FRONT) && (vtx_reg == 3'd0) && buf_valid_reg)
        else $error("new prism does not start at the front face");
`endif
endmodule
`default_nettype wire

### sv/box_prism_project_and_cull.sv
// Path: an accepted prism passes, in order, the following before its first vertex word shows:
// Two front stages, a 15-stage divider (one quotient bit per stage), then the result buffer.
// Throughput: one prism per cycle into the pipeline unless s_ready stalls it; the output
// channel carries one vertex word per cycle while m_ready is high, 5 to 20 words per prism.
// Reset: synchronous, active low; clears all valid bits and loads display_height 480 and
// view_distance 400.
`default_nettype none
module box_prism_project_and_cull #(
    parameter int PRISM_WIDTH = bpp_pkg::PRISM_WIDTH_DEF
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire                     cfg_index,
    input  wire [12:0]              cfg_data,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire signed [11:0]       s_pos_x,
    input  wire signed [11:0]       s_pos_depth,
    input  wire signed [11:0]       s_base_y,
    input  wire [9:0]               s_prism_height,
    output logic                    m_valid,
    input  wire                     m_ready,
    output logic [1:0]              m_face_kind,
    output logic signed [5:0]       m_draw_layer,
    output logic signed [15:0]      m_point_x,
    output logic signed [16:0]      m_point_y,
    output logic                    m_face_start,
    output logic                    m_last
);
    import bpp_pkg::*;

    logic [12:0] display_height_reg;
    logic [11:0] view_distance_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            display_height_reg <= 13'(DH_RESET);
            view_distance_reg <= 12'(VD_RESET);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DISPLAY_HEIGHT: display_height_reg <= cfg_data;
                REG_VIEW_DISTANCE: view_distance_reg <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic front_valid, div_valid, ld_ready;
    num_t front_num;
    side_t front_side, div_side;
    quot_t div_quot;

    assign en = !div_valid || ld_ready;
    assign s_ready = en;

    bpp_front #(.PRISM_WIDTH(PRISM_WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_valid),
        .pos_x(s_pos_x), .pos_depth(s_pos_depth), .base_y(s_base_y),
        .prism_height(s_prism_height), .display_height(display_height_reg),
        .view_distance(view_distance_reg), .out_valid(front_valid),
        .out_num(front_num), .out_side(front_side)
    );

    bpp_div u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(front_valid),
        .in_num(front_num), .in_side(front_side), .out_valid(div_valid),
        .out_quot(div_quot), .out_side(div_side)
    );

    bpp_emit u_emit (
        .aclk(aclk), .aresetn(aresetn), .in_valid(div_valid), .in_quot(div_quot),
        .in_side(div_side), .ld_ready(ld_ready), .m_valid(m_valid), .m_ready(m_ready),
        .m_face_kind(m_face_kind), .m_draw_layer(m_draw_layer), .m_point_x(m_point_x),
        .m_point_y(m_point_y), .m_face_start(m_face_start), .m_last(m_last)
    );
endmodule
`default_nettype wire

### verif/tb.sv
// Testbench for box_prism_project_and_cull: drives prisms and register writes.
// Predicts vertex words; depends on bpp_pkg and the box_prism_project_and_cull RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import bpp_pkg::*;

    typedef struct {
        logic signed [11:0] px;
        logic signed [11:0] pz;
        logic signed [11:0] by;
        logic [9:0]         ht;
        bit                 is_cfg;
        logic               idx;
        logic [12:0]        val;
    } prism_t;

    typedef struct {
        logic [1:0]         kind;
        logic signed [5:0]  layer;
        logic signed [15:0] x;
        logic signed [16:0] y;
        logic               start;
        logic               lst;
    } vertex_t;

    localparam int PW = 16;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_index = 1'b0;
    logic [12:0] cfg_data = '0;
    logic cfg_ready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [11:0] s_pos_x = '0, s_pos_depth = '0, s_base_y = '0;
    logic [9:0] s_prism_height = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_face_kind;
    logic signed [5:0] m_draw_layer;
    logic signed [15:0] m_point_x;
    logic signed [16:0] m_point_y;
    logic m_face_start, m_last;

    box_prism_project_and_cull uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_pos_x(s_pos_x),
        .s_pos_depth(s_pos_depth), .s_base_y(s_base_y), .s_prism_height(s_prism_height),
        .m_valid(m_valid), .m_ready(m_ready), .m_face_kind(m_face_kind),
        .m_draw_layer(m_draw_layer), .m_point_x(m_point_x), .m_point_y(m_point_y),
        .m_face_start(m_face_start), .m_last(m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    prism_t pending_q[$];
    vertex_t vertex_q[$];
    longint unsigned disp_h = DH_RESET, view_d = VD_RESET;
    int errors = 0, prisms_sent = 0, words_seen = 0, cfg_writes = 0;
    int drv_gap = 0, mon_gap = 0;
    longint cycles = 0;
    bit stim_done = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void project_corner(input longint cx, input longint cy,
                                           input longint cz, output longint sx,
                                           output longint sy);
        longint d, h;
        d = view_d;
        h = disp_h;
        if (cz > 0) begin
            sx = (cx * d) / (d + cz);
            sy = ((h - cy) * d) / (d + cz);
        end else begin
            sx = cx;
            sy = h - cy;
        end
    endfunction

    task automatic predict_vertices(input prism_t p);
        longint sx[8], sy[8];
        longint xl, xr, yb, yt, zf, zb, lay, lf, lt;
        int ord[4][5];
        bit show[4];
        longint lv[4];
        vertex_t v;
        int lastf;
        xl = 10 * longint'(p.px);
        xr = xl + 5 * PW;
        yb = 10 * longint'(p.by);
        yt = 10 * (longint'(p.by) + longint'(p.ht));
        zf = 3 * longint'(p.pz);
        zb = zf + 3 * PW;
        project_corner(xl, yb, zf, sx[0], sy[0]);
        project_corner(xr, yb, zf, sx[1], sy[1]);
        project_corner(xr, yb, zb, sx[2], sy[2]);
        project_corner(xl, yb, zb, sx[3], sy[3]);
        project_corner(xl, yt, zf, sx[4], sy[4]);
        project_corner(xr, yt, zf, sx[5], sy[5]);
        project_corner(xr, yt, zb, sx[6], sy[6]);
        project_corner(xl, yt, zb, sx[7], sy[7]);
        lay = (longint'(p.pz) / PW) % 31;
        lf = (lay < 30) ? lay + 2 : 31;
        lt = (lay < 31) ? lay + 1 : 31;
        ord = '{'{0, 1, 5, 4, 0}, '{4, 5, 6, 7, 4}, '{1, 2, 6, 5, 1}, '{0, 3, 7, 4, 0}};
        show = '{1'b1, sy[4] > sy[7], sx[1] < sx[2], sx[0] > sx[3]};
        lv = '{lf, lt, lay, lay};
        lastf = 0;
        for (int f = 0; f < 4; f++) if (show[f]) lastf = f;
        for (int f = 0; f < 4; f++) begin
            if (show[f]) begin
                for (int i = 0; i < 5; i++) begin
                    v.kind = 2'(f);
                    v.layer = 6'(lv[f]);
                    v.x = 16'(sx[ord[f][i]] + ((f == FACE_RIGHT) ? 1 : 0));
                    v.y = 17'(sy[ord[f][i]]);
                    v.start = (i == 0);
                    v.lst = (f == lastf) && (i == 4);
                    vertex_q.push_back(v);
                end
            end
        end
    endtask

    // Driver: prisms and register writes come from one queue, writes only when drained.
    always @(posedge aclk) begin
        bit busy;
        busy = 1'b0;
        if (!aresetn) begin
            s_valid <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                prisms_sent++;
                drv_gap = pick_gap();
            end else if (s_valid) begin
                busy = 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                cfg_writes++;
                drv_gap = 40;
            end else if (cfg_valid) begin
                busy = 1'b1;
            end
            if (!busy) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    s_valid <= 1'b0;
                    cfg_valid <= 1'b0;
                end else if (pending_q.size() > 0 && pending_q[0].is_cfg) begin
                    s_valid <= 1'b0;
                    if (vertex_q.size() == 0) begin
                        if (pending_q[0].idx == REG_DISPLAY_HEIGHT) disp_h = pending_q[0].val;
                        else view_d = pending_q[0].val[11:0];
                        cfg_index <= pending_q[0].idx;
                        cfg_data <= pending_q[0].val;
                        cfg_valid <= 1'b1;
                        void'(pending_q.pop_front());
                    end else begin
                        cfg_valid <= 1'b0;
                    end
                end else if (pending_q.size() > 0) begin
                    predict_vertices(pending_q[0]);
                    s_pos_x <= pending_q[0].px;
                    s_pos_depth <= pending_q[0].pz;
                    s_base_y <= pending_q[0].by;
                    s_prism_height <= pending_q[0].ht;
                    s_valid <= 1'b1;
                    cfg_valid <= 1'b0;
                    void'(pending_q.pop_front());
                end else begin
                    s_valid <= 1'b0;
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each vertex word with the oldest prediction.
    always @(posedge aclk) begin
        vertex_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                words_seen++;
                if (vertex_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected vertex word x=%0d y=%0d",
                                               m_point_x, m_point_y);
                end else begin
                    e = vertex_q.pop_front();
                    if (m_face_kind !== e.kind || m_draw_layer !== e.layer
                        || m_point_x !== e.x || m_point_y !== e.y
                        || m_face_start !== e.start || m_last !== e.lst) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch exp k=%0d l=%0d x=%0d y=%0d s=%0b e=%0b",
                                      " got k=%0d l=%0d x=%0d y=%0d s=%0b e=%0b"},
                                e.kind, e.layer, e.x, e.y, e.start, e.lst, m_face_kind,
                                m_draw_layer, m_point_x, m_point_y, m_face_start, m_last);
                    end
                end
            end
            if (mon_gap > 0) begin
                mon_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 7) == 0) mon_gap = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("box_prism_project_and_cull test failed");
            $finish;
        end
    end

    task automatic add_prism(input int x, input int z, input int y, input int h);
        prism_t p;
        p.is_cfg = 0;
        p.px = 12'(x);
        p.pz = 12'(z);
        p.by = 12'(y);
        p.ht = 10'(h);
        p.idx = 0;
        p.val = 0;
        pending_q.push_back(p);
    endtask

    task automatic add_write(input logic idx, input int val);
        prism_t p;
        p = '{default: 0};
        p.is_cfg = 1;
        p.idx = idx;
        p.val = 13'(val);
        pending_q.push_back(p);
    endtask

    task automatic add_random(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0)
                add_prism($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                          $urandom_range(0, 4095) - 2048, $urandom_range(0, 1023));
            else
                add_prism($urandom_range(0, 80) - 40, $urandom_range(0, 600) - 100,
                          $urandom_range(0, 100) - 50, $urandom_range(0, 60));
        end
    endtask

    initial begin
        add_prism(0, 0, 0, 0);
        add_prism(-2048, -2048, -2048, 0);
        add_prism(2047, 2047, 2047, 1023);
        add_prism(-2048, 2047, 2047, 1023);
        add_prism(2047, -2048, -2048, 1023);
        add_prism(-5, 20, -3, 10);
        add_prism(5, 20, -3, 10);
        add_prism(-5, 20, 60, 5);
        add_prism(-1, -15, 0, 4);
        add_prism(0, -16, 1, 1);
        add_prism(0, 480, 0, 8);
        add_prism(0, 496, 0, 8);
        add_prism(0, 511, 0, 8);
        add_prism(0, -496, 0, 8);
        add_prism(-8, 1, 0, 3);
        add_random(60);
        add_write(REG_VIEW_DISTANCE, 0);
        add_prism(3, 10, 2, 5);
        add_prism(-3, -10, 2, 5);
        add_random(30);
        add_write(REG_DISPLAY_HEIGHT, 8191);
        add_write(REG_VIEW_DISTANCE, 4095);
        add_random(50);
        add_write(REG_DISPLAY_HEIGHT, 0);
        add_write(REG_VIEW_DISTANCE, 1);
        add_random(40);
        add_write(REG_DISPLAY_HEIGHT, 4096);
        add_write(REG_VIEW_DISTANCE, 2048);
        add_random(40);
        add_write(REG_DISPLAY_HEIGHT, 1);
        add_write(REG_VIEW_DISTANCE, 400);
        add_random(40);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_q.size() == 0 && !s_valid && !cfg_valid);
        wait (vertex_q.size() == 0);
        repeat (60) @(posedge aclk);
        $display("Covered %0d prisms and %0d register writes, %0d vertex words checked.",
                 prisms_sent, cfg_writes, words_seen);
        if (errors == 0 && vertex_q.size() == 0)
            $display("box_prism_project_and_cull test passed");
        else
            $display("box_prism_project_and_cull test failed");
        $finish;
    end
endmodule
`default_nettype wire
